// ===== design/lzwe_pkg.sv =====
// Shared types and constants for the LZW byte encoder.
// Used by lzwe_out_fifo and lzw_byte_encoder; depends on nothing.
package lzwe_pkg;

  localparam logic [12:0] CODE_CLEAR  = 13'd256;
  localparam logic [12:0] CODE_END    = 13'd257;
  localparam int          FIRST_FREE  = 258;
  localparam int          START_WIDTH = 9;
  localparam int          ROOTS       = 256;
  localparam int          FIFO_DEPTH  = 4;
  localparam int          FIFO_PW     = $clog2(FIFO_DEPTH);

  // One result transaction as it leaves the block
  typedef struct packed {
    logic [12:0] code;
    logic [3:0]  width;
    logic        last;
  } res_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LINK  = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_MISS  = 8'b0000_1000,
    S_NEWE  = 8'b0001_0000,
    S_CLEAR = 8'b0010_0000,
    S_ENDP  = 8'b0100_0000,
    S_ENDC  = 8'b1000_0000
  } state_t;

endpackage

// ===== design/lzwe_out_fifo.sv =====
// Small result queue that decouples the encoder core from the output channel.
// Depends on lzwe_pkg (res_t, FIFO_DEPTH).
module lzwe_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lzwe_pkg::res_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lzwe_pkg::res_t  pop_data
);

  lzwe_pkg::res_t               slots [lzwe_pkg::FIFO_DEPTH];
  logic [lzwe_pkg::FIFO_PW-1:0] wr_ptr;
  logic [lzwe_pkg::FIFO_PW-1:0] rd_ptr;
  logic [lzwe_pkg::FIFO_PW:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (count != (lzwe_pkg::FIFO_PW+1)'(lzwe_pkg::FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/lzw_byte_encoder.sv =====
// LZW byte encoder top level: dictionary walk, insert and code emission.
// Depends on lzwe_pkg and lzwe_out_fifo.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, byte_in, end_of_buffer | in
//  result  | out_valid/out_ready, code, code_width,    | out
//          | run_last                                  |
//  config  | cfg_wr_en, cfg_wr_data (delta_mode)       | in
//
// On a dictionary hit a byte walks the sibling entries read from the entry
// memory (one read per cycle); a miss adds the insert, and a table clear or
// the end of a buffer adds its own states. The first byte of a run only
// loads the prefix, plus end handling.
// Reset is synchronous; root child bits clear at once, no clearing pass.
// A full 4-entry result queue stalls the emitting states only.
module lzw_byte_encoder #(
  parameter int MAX_CODES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] code,
  output logic [3:0]  code_width,
  output logic        run_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int CW = $clog2(MAX_CODES);
  localparam int NW = $clog2(MAX_CODES + 1);
  localparam int WW = $clog2(CW + 2);
  localparam int PW = NW + 1;

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] child;
  } link_t;

  typedef struct packed {
    logic [7:0]    chr;
    logic          sib_valid;
    logic [CW-1:0] sib;
  } ent_t;

  lzwe_pkg::state_t state;
  logic [CW-1:0]    prefix_code;
  logic             have_prefix;
  logic [NW-1:0]    next_free;
  logic [WW-1:0]    cur_width;
  logic [7:0]       previous_byte;
  logic             delta_mode;
  logic [7:0]       ch_q;
  logic             last_q;
  logic [CW-1:0]    node;
  logic             lk_valid;
  logic [CW-1:0]    lk_child;
  logic [lzwe_pkg::ROOTS-1:0] root_valid;

  link_t         link_mem [MAX_CODES];
  ent_t          ent_mem  [MAX_CODES];
  link_t         link_rd;
  ent_t          ent_rd;
  logic          link_we;
  logic [CW-1:0] link_wa;
  link_t         link_wd;
  logic          ent_we;
  logic [CW-1:0] ent_ra;

  logic [7:0]    ch_coded;
  logic          in_acc;
  logic          is_root;
  logic          parent_valid;
  logic [NW-1:0] nf_inc;
  logic          full_next;
  logic [WW-1:0] width_next;
  logic          push_valid;
  logic          push_ready;
  lzwe_pkg::res_t push_data;
  lzwe_pkg::res_t pop_data;
  logic          go;

  assign in_ready = (state == lzwe_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ch_coded = delta_mode ? (byte_in - previous_byte) : byte_in;
  assign is_root  = (prefix_code[CW-1:8] == '0);
  assign parent_valid = link_rd.valid && (!is_root || root_valid[prefix_code[7:0]]);
  assign nf_inc     = next_free + 1'b1;
  assign full_next  = (nf_inc >= NW'(MAX_CODES));
  assign width_next = (PW'(nf_inc) == (PW'(1) << cur_width)) ? cur_width + 1'b1 : cur_width;

  // Link memory: first child of each code, read at the prefix
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[prefix_code];
  end

  // Entry memory: character and sibling link of each added code
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[next_free[CW-1:0]] <= '{chr: ch_q, sib_valid: lk_valid, sib: lk_child};
    end
    ent_rd <= ent_mem[ent_ra];
  end

  // Select memory writes and the entry read address
  always_comb begin
    link_we = 1'b0;
    link_wa = prefix_code;
    link_wd = '{valid: 1'b1, child: next_free[CW-1:0]};
    ent_we  = 1'b0;
    ent_ra  = (state == lzwe_pkg::S_LINK) ? link_rd.child : ent_rd.sib;
    if (state == lzwe_pkg::S_MISS && go) begin
      // new entry starts with no children
      link_we = 1'b1;
      link_wa = next_free[CW-1:0];
      link_wd = '{valid: 1'b0, child: '0};
      ent_we  = 1'b1;
    end else if (state == lzwe_pkg::S_NEWE && go) begin
      link_we = 1'b1;
    end
  end

  // Choose the result transaction for the emitting states
  always_comb begin
    push_valid = 1'b0;
    push_data  = '{code: 13'(prefix_code), width: 4'(cur_width), last: 1'b0};
    unique case (state)
      lzwe_pkg::S_MISS: begin
        push_valid     = 1'b1;
        push_data.last = !full_next && !last_q;
      end
      lzwe_pkg::S_NEWE: begin
        push_valid = full_next;
        push_data  = '{code: 13'(ch_q), width: 4'(width_next), last: 1'b0};
      end
      lzwe_pkg::S_CLEAR: begin
        push_valid = 1'b1;
        push_data  = '{code: lzwe_pkg::CODE_CLEAR, width: 4'(cur_width), last: !last_q};
      end
      lzwe_pkg::S_ENDP: begin
        push_valid = 1'b1;
      end
      lzwe_pkg::S_ENDC: begin
        push_valid = 1'b1;
        push_data  = '{code: lzwe_pkg::CODE_END, width: 4'(cur_width), last: 1'b1};
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  assign go = !push_valid || push_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delta_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      delta_mode <= cfg_wr_data;
    end
  end

  // Sequencer: lookup, insert, clear and end handling
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lzwe_pkg::S_IDLE;
      prefix_code   <= '0;
      have_prefix   <= 1'b0;
      next_free     <= NW'(lzwe_pkg::FIRST_FREE);
      cur_width     <= WW'(lzwe_pkg::START_WIDTH);
      previous_byte <= '0;
      root_valid    <= '0;
      ch_q          <= '0;
      last_q        <= 1'b0;
    end else begin
      unique case (state)
        lzwe_pkg::S_IDLE: begin
          if (in_acc) begin
            ch_q   <= ch_coded;
            last_q <= end_of_buffer;
            if (delta_mode) begin
              previous_byte <= byte_in;
            end
            if (!have_prefix) begin
              prefix_code <= CW'(ch_coded);
              have_prefix <= 1'b1;
              state <= end_of_buffer ? lzwe_pkg::S_ENDP : lzwe_pkg::S_IDLE;
            end else begin
              state <= lzwe_pkg::S_LINK;
            end
          end
        end
        lzwe_pkg::S_LINK: begin
          lk_valid <= parent_valid;
          lk_child <= link_rd.child;
          node     <= link_rd.child;
          state    <= parent_valid ? lzwe_pkg::S_WALK : lzwe_pkg::S_MISS;
        end
        lzwe_pkg::S_WALK: begin
          if (ent_rd.chr == ch_q) begin
            prefix_code <= node;
            state <= last_q ? lzwe_pkg::S_ENDP : lzwe_pkg::S_IDLE;
          end else if (!ent_rd.sib_valid) begin
            state <= lzwe_pkg::S_MISS;
          end else begin
            node <= ent_rd.sib;
          end
        end
        lzwe_pkg::S_MISS: begin
          if (go) begin
            state <= lzwe_pkg::S_NEWE;
          end
        end
        lzwe_pkg::S_NEWE: begin
          if (go) begin
            if (is_root) begin
              root_valid[prefix_code[7:0]] <= 1'b1;
            end
            next_free   <= nf_inc;
            cur_width   <= width_next;
            prefix_code <= CW'(ch_q);
            if (full_next) begin
              state <= lzwe_pkg::S_CLEAR;
            end else begin
              state <= last_q ? lzwe_pkg::S_ENDP : lzwe_pkg::S_IDLE;
            end
          end
        end
        lzwe_pkg::S_CLEAR: begin
          if (go) begin
            // restart the dictionary
            previous_byte <= '0;
            next_free     <= NW'(lzwe_pkg::FIRST_FREE);
            cur_width     <= WW'(lzwe_pkg::START_WIDTH);
            root_valid    <= '0;
            have_prefix   <= 1'b0;
            prefix_code   <= '0;
            state <= last_q ? lzwe_pkg::S_ENDC : lzwe_pkg::S_IDLE;
          end
        end
        lzwe_pkg::S_ENDP: begin
          if (go) begin
            state <= lzwe_pkg::S_ENDC;
          end
        end
        lzwe_pkg::S_ENDC: begin
          if (go) begin
            have_prefix <= 1'b0;
            state <= lzwe_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lzwe_pkg::S_IDLE;
        end
      endcase
    end
  end

  lzwe_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (pop_data)
  );

  assign code       = pop_data.code;
  assign code_width = pop_data.width;
  assign run_last   = pop_data.last;

  // Free pointer stays inside the table between transactions
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (state == lzwe_pkg::S_IDLE) |->
      (next_free >= NW'(lzwe_pkg::FIRST_FREE) && next_free < NW'(MAX_CODES)))
    else $error("next_free out of range");

  // Code width never falls below the start width or past one bit above the table index width
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (cur_width >= WW'(lzwe_pkg::START_WIDTH) && cur_width <= WW'(CW + 1)))
    else $error("code width out of range");

  // A table clear always leads into a restarted dictionary
  a_clear_restart: assert property (@(posedge clk) disable iff (rst)
    (state == lzwe_pkg::S_CLEAR && go) |=>
      (next_free == NW'(lzwe_pkg::FIRST_FREE) && !have_prefix))
    else $error("clear did not restart the dictionary");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for lzw_byte_encoder: directed table, then random buffers.
// Depends on lzwe_pkg and the RTL of lzw_byte_encoder; runs with a small table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Smallest power-of-two table size that the block supports
  localparam int MAX = 512;
  localparam int IDLE_LIMIT = 5000;
  localparam int RAND_PER_PHASE = 34;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        end_of_buffer;
  logic        out_valid;
  logic        out_ready;
  logic [12:0] code;
  logic [3:0]  code_width;
  logic        run_last;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  lzw_byte_encoder #(.MAX_CODES(MAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_in(byte_in), .end_of_buffer(end_of_buffer),
    .out_valid(out_valid), .out_ready(out_ready),
    .code(code), .code_width(code_width), .run_last(run_last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Encoder model state
  logic [12:0] pfx;
  bit          have_pfx;
  int          nfree;
  int          cur_w;
  logic [7:0]  prev_byte;
  bit          delta_on;
  logic [7:0]  dict_char[MAX];
  int          dict_sib[MAX];
  bit          dict_sib_ok[MAX];
  int          dict_child[MAX];
  bit          dict_child_ok[MAX];

  lzwe_pkg::res_t code_q[$];
  int   mismatches;
  int   idle_cycles;
  bit   timed_out;
  int   burst_left;
  int   step_n;

  function automatic void restart_dict();
    nfree = lzwe_pkg::FIRST_FREE;
    cur_w = lzwe_pkg::START_WIDTH;
    prev_byte = 8'd0;
    for (int i = 0; i < MAX; i++) dict_child_ok[i] = 1'b0;
  endfunction

  function automatic void queue_code(int c);
    lzwe_pkg::res_t r;
    r.code  = c[12:0];
    r.width = cur_w[3:0];
    r.last  = 1'b0;
    code_q.push_back(r);
  endfunction

  // Walk the child and sibling chain of parent; -1 on a miss
  function automatic int find_entry(int parent, logic [7:0] ch);
    int node;
    if (parent >= MAX || !dict_child_ok[parent]) return -1;
    node = dict_child[parent];
    for (int g = 0; g < MAX; g++) begin
      if (dict_char[node] == ch) return node;
      if (!dict_sib_ok[node]) return -1;
      node = dict_sib[node];
    end
    return -1;
  endfunction

  // Advance the model by one byte and queue the codes it causes
  function automatic void encode_byte(logic [7:0] raw, logic eob);
    logic [7:0] ch;
    int hit;
    int start_n;
    ch = raw;
    start_n = code_q.size();
    if (delta_on) begin
      ch = raw - prev_byte;
      prev_byte = raw;
    end
    if (!have_pfx) begin
      pfx = {5'd0, ch};
      have_pfx = 1'b1;
    end else begin
      hit = find_entry(pfx, ch);
      if (hit >= 0) begin
        pfx = hit[12:0];
      end else begin
        queue_code(pfx);
        if (nfree < MAX) begin
          dict_char[nfree] = ch;
          dict_sib_ok[nfree] = dict_child_ok[pfx];
          dict_sib[nfree] = dict_child[pfx];
          dict_child_ok[nfree] = 1'b0;
          dict_child[pfx] = nfree;
          dict_child_ok[pfx] = 1'b1;
          nfree++;
        end
        if (nfree == (1 << cur_w)) cur_w++;
        pfx = {5'd0, ch};
        if (nfree >= MAX) begin
          queue_code(pfx);
          queue_code(lzwe_pkg::CODE_CLEAR);
          restart_dict();
          have_pfx = 1'b0;
          pfx = 13'd0;
        end
      end
    end
    if (eob) begin
      if (have_pfx) queue_code(pfx);
      queue_code(lzwe_pkg::CODE_END);
      have_pfx = 1'b0;
    end
    if (code_q.size() > start_n) code_q[code_q.size() - 1].last = 1'b1;
    step_n = code_q.size() - start_n;
  endfunction

  // Present one byte transaction after an optional random gap, hold until accepted, then update the model
  task automatic send_byte(logic [7:0] b, logic e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    byte_in <= b;
    end_of_buffer <= e;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_byte(b, e);
    @(negedge clk);
  endtask

  // Wait for the block to drain, then write delta_mode
  task automatic set_delta(bit v);
    in_valid <= 1'b0;
    while (code_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    delta_on = v;
  endtask

  // Receiver stall pattern: a randomly drawn rx_mode sets how out_ready is driven
  int rx_cycle;
  int rx_mode;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rx_cycle % 7) < 4);
    endcase
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    lzwe_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (code_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: code %0d width %0d last %0b",
                   code, code_width, run_last);
      end else begin
        want = code_q.pop_front();
        if (want.code !== code || want.width !== code_width || want.last !== run_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp code %0d width %0d last %0b, got %0d %0d %0b",
                     want.code, want.width, want.last, code, code_width, run_last);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("testbench: errors");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    logic       e;
    int         n;   // typed result count, -1 = use the model
    int         c0;
    int         c1;
  } row_t;

  row_t rows[] = '{
    '{8'h41, 1'b1, 2, 65, 257},    // single byte buffer after reset
    '{8'hFF, 1'b1, 2, 255, 257},   // top byte value
    '{8'h00, 1'b0, 0, 0, 0},       // first byte of a run: nothing out
    '{8'h00, 1'b0, 1, 0, 0},       // first miss emits the zero prefix
    '{8'h00, 1'b0, -1, 0, 0},
    '{8'h00, 1'b0, -1, 0, 0},
    '{8'hFF, 1'b0, -1, 0, 0},
    '{8'h00, 1'b0, -1, 0, 0},
    '{8'hFF, 1'b0, -1, 0, 0},
    '{8'h00, 1'b0, -1, 0, 0},
    '{8'hFF, 1'b0, -1, 0, 0},
    '{8'hAA, 1'b0, -1, 0, 0},
    '{8'h55, 1'b1, -1, 0, 0},
    '{8'h55, 1'b0, -1, 0, 0},
    '{8'h55, 1'b0, -1, 0, 0},
    '{8'h55, 1'b1, -1, 0, 0}
  };

  initial begin
    lzwe_pkg::res_t r;
    logic [7:0] b;
    logic e;
    rst = 1'b1;
    in_valid = 1'b0;
    byte_in = 8'd0;
    end_of_buffer = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    rx_cycle = 0;
    rx_mode = 0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    burst_left = 0;
    step_n = 0;
    pfx = 13'd0;
    have_pfx = 1'b0;
    delta_on = 1'b0;
    for (int i = 0; i < MAX; i++) begin
      dict_sib_ok[i] = 1'b0;
      dict_char[i] = 8'd0;
      dict_sib[i] = 0;
      dict_child[i] = 0;
    end
    restart_dict();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    set_delta(1'b0);
    foreach (rows[i]) begin
      send_byte(rows[i].b, rows[i].e);
      if (rows[i].n >= 0) begin
        // replace this byte's model results by the typed ones
        for (int k = 0; k < step_n; k++) r = code_q.pop_back();
        for (int k = 0; k < rows[i].n; k++) begin
          r.code = (k == 0) ? rows[i].c0[12:0] : rows[i].c1[12:0];
          r.width = 4'd9;
          r.last = (k == rows[i].n - 1);
          code_q.push_back(r);
        end
      end
    end

    // Random buffers in four phases, with delta mode alternating off and on
    for (int ph = 0; ph < 4; ph++) begin
      set_delta(ph[0]);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 255));
        else b = {6'd0, 2'($urandom_range(0, 3))} + 8'h61;
        e = ($urandom_range(0, 39) == 0);
        // aim the last byte of a buffer at the table-full point now and then
        if (nfree == MAX - 1 && have_pfx) e = 1'($urandom_range(0, 1));
        if (i == RAND_PER_PHASE - 1) e = 1'b1;
        send_byte(b, e);
      end
    end
    set_delta(1'b0);

    in_valid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
